/* src/rgba_box_downsample_2x2_macros.svh */
// ----------------------------------------------------------------------------
// RGBA 2x2 box downsampler assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef RGBA_BOX_DOWNSAMPLE_2X2_MACROS_SVH
`define RGBA_BOX_DOWNSAMPLE_2X2_MACROS_SVH

// Condition in this cycle implies the check in this cycle.
`define RBD_ASSERT_NOW(lbl, cond, chk, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (chk)) else $error(msg);

// Condition in this cycle implies the check in the next cycle.
`define RBD_ASSERT_NEXT(lbl, cond, chk, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (chk)) else $error(msg);

`endif

/* src/rbd2x2_pkg.sv */
// ----------------------------------------------------------------------------
// RGBA 2x2 box downsampler package
// Register indexes, payload types and the per-channel sum/mean functions.
// ----------------------------------------------------------------------------
package rbd2x2_pkg;

    localparam int CFG_ADDR_W  = 8;
    localparam int CFG_DATA_W  = 13;
    localparam int PIXEL_W     = 32;
    localparam int CHAN_W      = 8;
    localparam int PAIR_CH_W   = 9;
    localparam int NUM_CHAN    = 4;
    localparam int PAIR_W      = NUM_CHAN * PAIR_CH_W;

    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [PIXEL_W-1:0]    t_pixel;
    typedef logic [PAIR_W-1:0]     t_pair_sum;

    localparam t_cfg_addr CFG_IMAGE_WIDTH  = t_cfg_addr'(0);
    localparam t_cfg_addr CFG_IMAGE_HEIGHT = t_cfg_addr'(1);

    // Four 9-bit channel sums of two horizontally adjacent pixels.
    function automatic t_pair_sum pair_sum(input t_pixel a, input t_pixel b);
        t_pair_sum r;
        r = '0;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            r[PAIR_CH_W*ch +: PAIR_CH_W] = {1'b0, a[CHAN_W*ch +: CHAN_W]}
                                         + {1'b0, b[CHAN_W*ch +: CHAN_W]};
        end
        return r;
    endfunction

    // Sum top and bottom pair sums per channel, divide by four (truncate).
    function automatic t_pixel block_mean(input t_pair_sum top, input t_pair_sum bot);
        t_pixel              r;
        logic [PAIR_CH_W:0]  s;
        r = '0;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            s = {1'b0, top[PAIR_CH_W*ch +: PAIR_CH_W]}
              + {1'b0, bot[PAIR_CH_W*ch +: PAIR_CH_W]};
            r[CHAN_W*ch +: CHAN_W] = s[PAIR_CH_W:2];
        end
        return r;
    endfunction

endpackage

/* src/rgba_box_downsample_2x2.sv */
// ----------------------------------------------------------------------------
// RGBA 2x2 box downsampler
// Averages each 2x2 block of an RGBA8888 raster stream into one pixel.
// Pair sums of even rows sit in a line memory and are read back on odd rows.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                       payload
//  pixel     in         i_pixel_valid / o_pixel_ready   i_pixel
//  avg       out        o_avg_valid / i_avg_ready       o_avg_pixel, o_last
//  cfg       in         i_cfg_we (no wait)              i_cfg_addr, i_cfg_wdata
//
// One pixel per clock sustained while results are taken; after the lower-right
// pixel of its block, a result passes through the line memory read and then the
// output register. Input ready follows output ready through the two stages.
// Synchronous active-low reset; the line memory is not cleared, an odd row
// only reads entries written by the even row before it.
// A write to either size register restarts the frame counters.
// ----------------------------------------------------------------------------
`include "rgba_box_downsample_2x2_macros.svh"

module rgba_box_downsample_2x2 #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  rbd2x2_pkg::t_cfg_addr i_cfg_addr,
    input  rbd2x2_pkg::t_cfg_data i_cfg_wdata,
    input  logic                  i_pixel_valid,
    output logic                  o_pixel_ready,
    input  rbd2x2_pkg::t_pixel    i_pixel,
    output logic                  o_avg_valid,
    input  logic                  i_avg_ready,
    output rbd2x2_pkg::t_pixel    o_avg_pixel,
    output logic                  o_last
);
    import rbd2x2_pkg::*;

    localparam int CW_RAW     = $clog2(MAX_WIDTH);
    localparam int CW         = (CW_RAW < 2) ? 2 : CW_RAW;
    localparam int RW_RAW     = $clog2(MAX_HEIGHT);
    localparam int RW         = (RW_RAW < 1) ? 1 : RW_RAW;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    // frame geometry, derived at configuration time
    logic [CW-1:0] r_col_max, r_last_col;
    logic [RW-1:0] r_row_max, r_last_row;
    logic [31:0]   cfg_v, cfg_eff;

    // position and left pixel of the current pair
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    t_pixel        r_held;

    // line memory
    t_pair_sum     r_line [LINE_DEPTH];
    t_pair_sum     r_line_q;
    logic [AW-1:0] line_addr;

    // stage 1: bottom pair sum waiting on the line read
    logic          r_s1_valid;
    t_pair_sum     r_s1_pair;
    logic          r_s1_last;

    // output register
    logic          r_out_valid;
    t_pixel        r_out_pixel;
    logic          r_out_last;

    logic          in_acc, s1_adv, odd_col, odd_row, col_end;
    logic          line_wr, line_rd;
    t_pair_sum     cur_pair;

    assign s1_adv        = !r_out_valid || i_avg_ready;
    assign o_pixel_ready = !r_s1_valid || s1_adv;
    assign in_acc        = i_pixel_valid && o_pixel_ready;

    assign odd_col   = r_col[0];
    assign odd_row   = r_row[0];
    assign col_end   = (r_col == r_col_max);
    assign cur_pair  = pair_sum(r_held, i_pixel);
    assign line_addr = AW'(r_col >> 1);
    assign line_wr   = in_acc && odd_col && !odd_row;
    assign line_rd   = in_acc && odd_col && odd_row;

    // clamp a size register value to 1..MAX
    function automatic logic [31:0] eff_size(input logic [31:0] v, input int maxv);
        logic [31:0] r;
        if (v == 32'd0) begin
            r = 32'd1;
        end else if (v > 32'(maxv)) begin
            r = 32'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign cfg_v   = 32'(i_cfg_wdata);
    assign cfg_eff = (i_cfg_addr == CFG_IMAGE_WIDTH) ? eff_size(cfg_v, MAX_WIDTH)
                                                     : eff_size(cfg_v, MAX_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_max  <= CW'(1);
            r_last_col <= CW'(1);
            r_row_max  <= RW'(1);
            r_last_row <= RW'(1);
            r_col      <= '0;
            r_row      <= '0;
            r_held     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_IMAGE_WIDTH: begin
                    r_col_max  <= CW'(cfg_eff - 32'd1);
                    r_last_col <= CW'((cfg_eff & ~32'd1) - 32'd1);
                    r_col      <= '0;
                    r_row      <= '0;
                    r_held     <= '0;
                end
                CFG_IMAGE_HEIGHT: begin
                    r_row_max  <= RW'(cfg_eff - 32'd1);
                    r_last_row <= RW'((cfg_eff & ~32'd1) - 32'd1);
                    r_col      <= '0;
                    r_row      <= '0;
                    r_held     <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_acc) begin
            if (!odd_col) begin
                r_held <= i_pixel;
            end
            // advance raster position, wrap at frame end
            if (col_end) begin
                r_col <= '0;
                r_row <= (r_row == r_row_max) ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Writes happen on even rows and reads on odd rows, so the two never hit
    // the same entry in overlapping cycles.
    always_ff @(posedge i_clk) begin
        if (line_wr) begin
            r_line[line_addr] <= cur_pair;
        end
        if (line_rd) begin
            r_line_q <= r_line[line_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= line_rd;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (line_rd) begin
            r_s1_pair <= cur_pair;
            r_s1_last <= (r_col == r_last_col) && (r_row == r_last_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_pixel <= block_mean(r_line_q, r_s1_pair);
            r_out_last  <= r_s1_last;
        end
    end

    assign o_avg_valid = r_out_valid;
    assign o_avg_pixel = r_out_pixel;
    assign o_last      = r_out_last;

    `RBD_ASSERT_NOW(a_col_in_row, 1'b1, r_col <= r_col_max, "column past row end")
    `RBD_ASSERT_NOW(a_row_in_frame, 1'b1, r_row <= r_row_max, "row past frame end")
    `RBD_ASSERT_NEXT(a_block_to_s1, line_rd, r_s1_valid, "block item lost after line read")
    `RBD_ASSERT_NEXT(a_s1_hold, r_s1_valid && !s1_adv,
        r_s1_valid && $stable(r_s1_pair) && $stable(r_line_q), "stalled block item changed")
    `RBD_ASSERT_NOW(a_no_rw_clash, line_wr, !line_rd, "line write and read together")

endmodule

/* sim/rgba_box_downsample_2x2_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGBA 2x2 box downsampler testbench
// Streams RGBA8888 frames of many sizes through the block, predicts each
// averaged pixel and its last flag, and checks every result in order under
// random gaps on the pixel side and random stalls on the result side.
// ----------------------------------------------------------------------------
module rgba_box_downsample_2x2_test;

    import rbd2x2_pkg::*;

    localparam int          MAX_DIM        = 4096;
    localparam int          LINE_ENTRIES   = MAX_DIM / 2;
    localparam int          RESULT_LATENCY = 2;
    localparam int          DRAIN_CYCLES   = 3 * RESULT_LATENCY;
    localparam int          RANDOM_ITEMS   = 1500;
    localparam int          CYCLE_LIMIT    = 2000000;
    localparam int          MAX_REPORTS    = 40;

    typedef logic [3:0][8:0] t_chan_pair;

    typedef struct packed {
        t_pixel avg;
        logic   last;
    } t_avg_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    t_cfg_addr  i_cfg_addr = '0;
    t_cfg_data  i_cfg_wdata = '0;
    logic       i_pixel_valid = 1'b0;
    logic       o_pixel_ready;
    t_pixel     i_pixel = '0;
    logic       o_avg_valid;
    logic       i_avg_ready = 1'b0;
    t_pixel     o_avg_pixel;
    logic       o_last;

    rgba_box_downsample_2x2 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_ready (o_pixel_ready),
        .i_pixel       (i_pixel),
        .o_avg_valid   (o_avg_valid),
        .i_avg_ready   (i_avg_ready),
        .o_avg_pixel   (o_avg_pixel),
        .o_last        (o_last)
    );

    // Shadow of the block: registers, frame position, line of pair sums.
    t_cfg_data   width_reg = t_cfg_data'(2);
    t_cfg_data   height_reg = t_cfg_data'(2);
    t_pixel      left_pixel = '0;
    int unsigned next_col = 0;
    int unsigned next_row = 0;
    t_chan_pair  even_row_sums [LINE_ENTRIES];

    t_pixel      queued_pixels [$];
    t_avg_item   awaited_avgs [$];
    int unsigned pixels_sent = 0;
    int unsigned pixels_taken = 0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;

    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;
    bit          src_hold;
    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;
    t_avg_item   want;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_dim(input t_cfg_data v);
        if (v == '0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    function automatic int unsigned draw_gap(input bit enabled);
        int unsigned r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Channels lean on 0 and 255 now and then so carries get exercised.
    function automatic t_pixel random_pixel();
        t_pixel px;
        int unsigned pick;
        px = $urandom;
        for (int ch = 0; ch < 4; ch++) begin
            pick = $urandom_range(0, 7);
            if (pick == 0)
                px[8*ch +: 8] = 8'h00;
            else if (pick == 1)
                px[8*ch +: 8] = 8'hff;
        end
        return px;
    endfunction

    // Advance the shadow by one accepted pixel; queue the average it completes.
    task automatic step_box_filter(input t_pixel px);
        int unsigned w, h, col, row, slot;
        t_chan_pair  sums;
        t_avg_item   res;
        logic [9:0]  total;
        w    = eff_dim(width_reg);
        h    = eff_dim(height_reg);
        col  = next_col;
        row  = next_row;
        slot = (col >> 1) % LINE_ENTRIES;
        if (col >= w)
            col = 0;
        if (row >= h)
            row = 0;
        if (col % 2 == 0) begin
            left_pixel = px;
        end else begin
            for (int ch = 0; ch < 4; ch++)
                sums[ch] = left_pixel[8*ch +: 8] + px[8*ch +: 8];
            if (row % 2 == 0) begin
                even_row_sums[slot] = sums;
            end else begin
                res = '0;
                for (int ch = 0; ch < 4; ch++) begin
                    total = even_row_sums[slot][ch] + sums[ch];
                    res.avg[8*ch +: 8] = total[9:2];
                end
                res.last = (col == (w & ~1) - 1) && (row == (h & ~1) - 1);
                awaited_avgs.push_back(res);
            end
        end
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h)
                row = 0;
        end
        next_col = col;
        next_row = row;
    endtask

    // Pixel driver: hold the item until accepted, then idle for a drawn gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pixel_valid <= 1'b0;
            src_gap = 0;
        end else begin
            src_hold = i_pixel_valid && !o_pixel_ready;
            if (i_pixel_valid && o_pixel_ready) begin
                step_box_filter(i_pixel);
                pixels_taken++;
                src_gap = draw_gap(src_idle_on);
            end
            if (!src_hold) begin
                if (src_gap == 0 && queued_pixels.size() != 0) begin
                    i_pixel       <= queued_pixels.pop_front();
                    i_pixel_valid <= 1'b1;
                end else begin
                    i_pixel_valid <= 1'b0;
                    if (src_gap != 0)
                        src_gap--;
                end
            end
        end
    end

    // Result monitor: compare each accepted item, then stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_avg_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (o_avg_valid && i_avg_ready) begin
                if (awaited_avgs.size() == 0) begin
                    if (errors < MAX_REPORTS)
                        $display("%0t: unexpected result avg_pixel=%h last=%b",
                                 $time, o_avg_pixel, o_last);
                    errors++;
                end else begin
                    want = awaited_avgs.pop_front();
                    if (o_avg_pixel !== want.avg) begin
                        if (errors < MAX_REPORTS)
                            $display("%0t: avg_pixel expected %h actual %h",
                                     $time, want.avg, o_avg_pixel);
                        errors++;
                    end
                    if (o_last !== want.last) begin
                        if (errors < MAX_REPORTS)
                            $display("%0t: last expected %b actual %b",
                                     $time, want.last, o_last);
                        errors++;
                    end
                end
            end
            if (sink_gap != 0) begin
                sink_gap--;
                i_avg_ready <= 1'b0;
            end else begin
                i_avg_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    sink_gap = draw_gap(sink_idle_on);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic write_reg(input t_cfg_addr addr, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= t_cfg_data'(value);
        if (addr == CFG_IMAGE_WIDTH || addr == CFG_IMAGE_HEIGHT) begin
            if (addr == CFG_IMAGE_WIDTH)
                width_reg = t_cfg_data'(value);
            else
                height_reg = t_cfg_data'(value);
            left_pixel = '0;
            next_col   = 0;
            next_row   = 0;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_pixel(input t_pixel px);
        queued_pixels.push_back(px);
        pixels_sent++;
    endtask

    task automatic queue_random(input int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            queue_pixel(random_pixel());
    endtask

    // Let every item in flight land before the next register write.
    task automatic wait_drained();
        while (pixels_taken != pixels_sent)
            @(posedge i_clk);
        while (awaited_avgs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_dim();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        if (r < 15)
            return 1;
        if (r < 85)
            return $urandom_range(2, 8);
        return $urandom_range(9, 24);
    endfunction

    initial begin
        int unsigned random_items;
        int unsigned action;
        int unsigned n;
        int unsigned w;
        int unsigned h;

        for (int k = 0; k < LINE_ENTRIES; k++)
            even_row_sums[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset size 2x2: one dark corner, then the mask constants pattern.
        queue_pixel(32'h0000_0000);
        queue_pixel(32'hffff_ffff);
        queue_pixel(32'hffff_ffff);
        queue_pixel(32'hffff_ffff);
        queue_pixel(32'h00ff_00ff);
        queue_pixel(32'hff00_ff00);
        queue_pixel(32'hff00_ff00);
        queue_pixel(32'h00ff_00ff);
        // Half a block, an out-of-range register write, then the rest.
        queue_pixel(32'h0102_0301);
        queue_pixel(32'h0001_0203);
        wait_drained();
        write_reg(t_cfg_addr'(255), 8191);
        queue_pixel(32'h0300_0102);
        queue_pixel(32'h0203_0001);
        wait_drained();
        // Odd column and odd row get dropped.
        write_reg(CFG_IMAGE_WIDTH, 3);
        write_reg(CFG_IMAGE_HEIGHT, 3);
        queue_random(9);
        wait_drained();
        // Zero width acts as one: no block ever completes.
        write_reg(CFG_IMAGE_WIDTH, 0);
        write_reg(CFG_IMAGE_HEIGHT, 2);
        queue_random(4);
        wait_drained();

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            action = $urandom_range(0, 9);
            if (action <= 6) begin
                if ($urandom_range(0, 1)) begin
                    write_reg(CFG_IMAGE_WIDTH, pick_dim());
                    write_reg(CFG_IMAGE_HEIGHT, pick_dim());
                end else begin
                    write_reg(CFG_IMAGE_HEIGHT, pick_dim());
                    write_reg(CFG_IMAGE_WIDTH, pick_dim());
                end
            end else if (action == 7) begin
                if ($urandom_range(0, 1))
                    write_reg(CFG_IMAGE_WIDTH, pick_dim());
                else
                    write_reg(CFG_IMAGE_HEIGHT, pick_dim());
            end else if (action == 8) begin
                write_reg(t_cfg_addr'($urandom_range(2, 255)), $urandom_range(0, 8191));
            end
            w = eff_dim(width_reg);
            h = eff_dim(height_reg);
            if ($urandom_range(0, 9) < 7)
                n = $urandom_range(1, 2) * w * h;
            else
                n = $urandom_range(1, 40);
            queue_random(n);
            random_items += n;
            wait_drained();
        end

        if (errors == 0 && awaited_avgs.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/rbd2x2_pkg.sv
src/rgba_box_downsample_2x2.sv
sim/rgba_box_downsample_2x2_test.sv
